@@ rtl/dfe_pkg.sv @@
// Shared types and constants for the delimited frame extractor.
// No dependencies; every other file in rtl/ imports this package.
package dfe_pkg;

    // Default sizing of the byte window and the packet buffer
    localparam int          MAX_PAYLOAD_DEF  = 32;
    localparam int unsigned BUFFER_BYTES_DEF = 32'd65536;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 6;
    localparam int PKTS_W    = 17;
    localparam int ADDR_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 17;

    // Frame markers
    localparam logic [BYTE_W-1:0] START_MARK = 8'h26;
    localparam logic [BYTE_W-1:0] END_MARK   = 8'h0A;

    // Configuration reset values
    localparam logic [LEN_W-1:0]  LEN_RESET  = 6'd11;
    localparam logic [PKTS_W-1:0] PKTS_RESET = 17'd5957;
    localparam logic [PKTS_W-1:0] PKTS_MAX   = 17'd65536;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAYLOAD_LENGTH = 1'b0,
        REG_BUFFER_PACKETS = 1'b1
    } t_cfg_reg;

    // Per-cycle control handed to every cell of the row
    typedef struct packed {
        logic win_shift;
        logic hold_load;
        logic emit_from_win;
        logic emit_from_hold;
        logic emit_shift;
    } t_cell_ctl;

endpackage

@@ rtl/dfe_if.sv @@
// Handshake channels of the delimited frame extractor: byte input,
// store requests out, and register writes. Depends on dfe_pkg.
interface dfe_in_if;
    import dfe_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    modport source (output valid, rx_byte, input ready);
    modport sink   (input valid, rx_byte, output ready);
endinterface

interface dfe_out_if;
    import dfe_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] store_address;
    logic [BYTE_W-1:0] store_byte;
    logic [ADDR_W-1:0] packet_number;
    logic [ADDR_W-1:0] round_count;
    logic              last_of_frame;
    modport source (output valid, store_address, store_byte, packet_number,
                    round_count, last_of_frame, input ready);
    modport sink   (input valid, store_address, store_byte, packet_number,
                    round_count, last_of_frame, output ready);
endinterface

interface dfe_cfg_if;
    import dfe_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/dfe_cell.sv @@
// One byte position of the extractor: window tap, frame hold byte and
// output shift byte. Depends on dfe_pkg.
module dfe_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dfe_pkg::t_cell_ctl        i_ctl,
    input  logic [dfe_pkg::BYTE_W-1:0] i_win_prev,
    input  logic [dfe_pkg::BYTE_W-1:0] i_emit_prev,
    output logic [dfe_pkg::BYTE_W-1:0] o_win,
    output logic [dfe_pkg::BYTE_W-1:0] o_emit,
    output logic                      o_is_start
);
    import dfe_pkg::*;

    logic [BYTE_W-1:0] r_win;
    logic [BYTE_W-1:0] r_hold;
    logic [BYTE_W-1:0] r_emit;

    // Advance the window tap; it must start as zero, never a start marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_ctl.win_shift) begin
            r_win <= i_win_prev;
        end
    end

    // Park the payload byte while the output row is still busy
    always_ff @(posedge i_clk) begin
        if (i_ctl.hold_load) begin
            r_hold <= r_win;
        end
    end

    // Load a new frame or shift toward the output end
    always_ff @(posedge i_clk) begin
        if (i_ctl.emit_from_win) begin
            r_emit <= r_win;
        end else if (i_ctl.emit_from_hold) begin
            r_emit <= r_hold;
        end else if (i_ctl.emit_shift) begin
            r_emit <= i_emit_prev;
        end
    end

    assign o_win      = r_win;
    assign o_emit     = r_emit;
    assign o_is_start = (r_win == START_MARK);

endmodule

@@ rtl/delimited_frame_extractor.sv @@
// Delimited frame extractor: finds '&', payload_length bytes, '\n' frames in
// a byte stream and turns each payload into store requests, one per byte,
// oldest byte first, with ring-buffer address, packet index and wrap count.
// Depends on dfe_pkg, dfe_if and dfe_cell.
//
// Rate: one received byte per cycle while the hold row is free, and one store
// request per cycle while the receiver is ready. The payload of a frame is
// snapped from the row of byte cells when its '\n' arrives, into the output
// row if that row is free, and leaves it one byte at a time. A second row of
// hold bytes takes one more frame while the output row is still busy; the
// byte input stalls only while that hold row is full.
module delimited_frame_extractor #(
    parameter int          MAX_PAYLOAD  = dfe_pkg::MAX_PAYLOAD_DEF,
    parameter int unsigned BUFFER_BYTES = dfe_pkg::BUFFER_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dfe_in_if.sink     i_rx,
    dfe_out_if.source  o_st,
    dfe_cfg_if.sink    i_cfg
);
    import dfe_pkg::*;

    localparam int          WinDepth = MAX_PAYLOAD + 1;
    localparam int          SelW     = $clog2(MAX_PAYLOAD + 1);
    localparam int          EmitW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int unsigned SpanI    = (BUFFER_BYTES > 32'd65536) ? 32'd65536
                                                                  : BUFFER_BYTES;
    localparam logic [ADDR_W:0] Span = (ADDR_W + 1)'(SpanI);

    // Configuration registers
    logic [LEN_W-1:0]  r_cfg_len;
    logic [PKTS_W-1:0] r_cfg_pkts;

    // Frame search and ring bookkeeping
    logic [LEN_W-1:0]  r_blk, n_blk;
    logic [ADDR_W-1:0] r_ring, n_ring;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [ADDR_W-1:0] r_rounds, n_rounds;
    logic [BYTE_W-1:0] r_win_tail;

    // Hold and output metadata
    logic              r_hold_valid, n_hold_valid;
    logic [ADDR_W-1:0] r_hold_base, r_hold_ring, r_hold_rounds;
    logic [LEN_W-1:0]  r_emit_cnt, n_emit_cnt;
    logic [ADDR_W-1:0] r_emit_addr, n_emit_addr;
    logic [ADDR_W-1:0] r_emit_ring, n_emit_ring;
    logic [ADDR_W-1:0] r_emit_rounds, n_emit_rounds;

    logic [LEN_W-1:0]  len_eff;
    logic [LEN_W-1:0]  len_m1;
    logic [PKTS_W-1:0] pkts_eff;
    logic [LEN_W-1:0]  blk_dec;
    logic              blocked;
    logic              in_fire;
    logic              frame;
    logic              pop;
    logic              emit_free;
    logic [ADDR_W:0]   base_sum;
    logic [ADDR_W:0]   ring_inc;
    logic [ADDR_W:0]   addr_inc;
    t_cell_ctl         ctl;

    logic [BYTE_W-1:0]  win  [MAX_PAYLOAD];
    logic [BYTE_W-1:0]  emit [MAX_PAYLOAD];
    logic [MAX_PAYLOAD:0] start_vec;

    // Accept register writes at any time
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len  <= LEN_RESET;
            r_cfg_pkts <= PKTS_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_PAYLOAD_LENGTH: r_cfg_len  <= i_cfg.data[LEN_W-1:0];
                REG_BUFFER_PACKETS: r_cfg_pkts <= i_cfg.data[PKTS_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the registers to their working ranges
    always_comb begin
        if (r_cfg_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_cfg_len > LEN_W'(MAX_PAYLOAD)) begin
            len_eff = LEN_W'(MAX_PAYLOAD);
        end else begin
            len_eff = r_cfg_len;
        end
        if (r_cfg_pkts == '0) begin
            pkts_eff = PKTS_W'(1);
        end else if (r_cfg_pkts > PKTS_MAX) begin
            pkts_eff = PKTS_MAX;
        end else begin
            pkts_eff = r_cfg_pkts;
        end
    end

    assign len_m1 = len_eff - LEN_W'(1);

    // Row of byte cells: window, hold row and output row
    for (genvar j = 0; j < MAX_PAYLOAD; j++) begin : g_cell
        logic [BYTE_W-1:0] win_prev;
        logic [BYTE_W-1:0] emit_prev;
        if (j == 0) begin : g_head
            assign win_prev  = i_rx.rx_byte;
            assign emit_prev = '0;
        end else begin : g_body
            assign win_prev  = win[j-1];
            assign emit_prev = emit[j-1];
        end
        dfe_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_win_prev  (win_prev),
            .i_emit_prev (emit_prev),
            .o_win       (win[j]),
            .o_emit      (emit[j]),
            .o_is_start  (start_vec[j])
        );
    end

    // Oldest window byte, only looked at for its start marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_tail <= '0;
        end else if (in_fire) begin
            r_win_tail <= win[MAX_PAYLOAD-1];
        end
    end
    assign start_vec[MAX_PAYLOAD] = (r_win_tail == START_MARK);

    // Frame detection
    assign i_rx.ready = !r_hold_valid;
    assign in_fire    = i_rx.valid && i_rx.ready;
    assign pop        = o_st.valid && o_st.ready;
    assign blk_dec    = (r_blk == '0) ? '0 : r_blk - LEN_W'(1);
    assign blocked    = blk_dec >= (LEN_W'(WinDepth) - len_eff);
    assign frame      = in_fire && (i_rx.rx_byte == END_MARK)
                        && start_vec[len_eff[SelW-1:0]] && !blocked;
    assign emit_free  = (r_emit_cnt == '0) || ((r_emit_cnt == LEN_W'(1)) && pop);

    // Cell row control
    always_comb begin
        ctl.win_shift      = in_fire;
        ctl.emit_from_win  = frame && emit_free;
        ctl.hold_load      = frame && !emit_free;
        ctl.emit_from_hold = r_hold_valid && emit_free;
        ctl.emit_shift     = pop;
    end

    // Advance ring index, packet base and wrap count per accepted frame; count down the block counter per byte
    always_comb begin
        base_sum = {1'b0, r_base} + (ADDR_W + 1)'(len_eff);
        ring_inc = {1'b0, r_ring} + (ADDR_W + 1)'(1);
        n_blk    = r_blk;
        n_ring   = r_ring;
        n_base   = r_base;
        n_rounds = r_rounds;
        if (frame) begin
            n_blk = LEN_W'(WinDepth);
            if (base_sum >= Span) begin
                n_base = ADDR_W'(base_sum - Span);
            end else begin
                n_base = base_sum[ADDR_W-1:0];
            end
            if ((PKTS_W)'(ring_inc) >= pkts_eff) begin
                n_ring   = '0;
                n_base   = '0;
                n_rounds = r_rounds + ADDR_W'(1);
            end else begin
                n_ring = ring_inc[ADDR_W-1:0];
            end
        end else if (in_fire) begin
            n_blk = blk_dec;
        end
    end

    // Output row bookkeeping
    always_comb begin
        addr_inc      = {1'b0, r_emit_addr} + (ADDR_W + 1)'(1);
        n_hold_valid  = r_hold_valid;
        n_emit_cnt    = r_emit_cnt;
        n_emit_addr   = r_emit_addr;
        n_emit_ring   = r_emit_ring;
        n_emit_rounds = r_emit_rounds;
        if (ctl.hold_load) begin
            n_hold_valid = 1'b1;
        end else if (ctl.emit_from_hold) begin
            n_hold_valid = 1'b0;
        end
        if (ctl.emit_from_win) begin
            n_emit_cnt    = len_eff;
            n_emit_addr   = r_base;
            n_emit_ring   = r_ring;
            n_emit_rounds = r_rounds;
        end else if (ctl.emit_from_hold) begin
            n_emit_cnt    = len_eff;
            n_emit_addr   = r_hold_base;
            n_emit_ring   = r_hold_ring;
            n_emit_rounds = r_hold_rounds;
        end else if (pop) begin
            n_emit_cnt  = r_emit_cnt - LEN_W'(1);
            n_emit_addr = (addr_inc == Span) ? '0 : addr_inc[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk        <= '0;
            r_ring       <= '0;
            r_base       <= '0;
            r_rounds     <= '0;
            r_hold_valid <= 1'b0;
            r_emit_cnt   <= '0;
        end else begin
            r_blk        <= n_blk;
            r_ring       <= n_ring;
            r_base       <= n_base;
            r_rounds     <= n_rounds;
            r_hold_valid <= n_hold_valid;
            r_emit_cnt   <= n_emit_cnt;
        end
    end

    // Hold a parked frame's ring position alongside its bytes; register the output row's metadata
    always_ff @(posedge i_clk) begin
        if (ctl.hold_load) begin
            r_hold_base   <= r_base;
            r_hold_ring   <= r_ring;
            r_hold_rounds <= r_rounds;
        end
        r_emit_addr   <= n_emit_addr;
        r_emit_ring   <= n_emit_ring;
        r_emit_rounds <= n_emit_rounds;
    end

    // Store request outputs; the oldest payload byte sits at the row's far end
    assign o_st.valid         = (r_emit_cnt != '0);
    assign o_st.store_address = r_emit_addr;
    assign o_st.store_byte    = emit[len_m1[EmitW-1:0]];
    assign o_st.packet_number = r_emit_ring;
    assign o_st.round_count   = r_emit_rounds;
    assign o_st.last_of_frame = (r_emit_cnt == LEN_W'(1));

    // A parked frame only exists behind a frame still being sent
    a_hold_behind_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> (r_emit_cnt != '0))
        else $error("hold row full while output row empty");

    // Output row never claims more bytes than it has cells
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_cnt <= LEN_W'(MAX_PAYLOAD))
        else $error("output byte count beyond row length");

    // An accepted frame blocks overlapping candidates
    a_block_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame |=> (r_blk == LEN_W'(WinDepth)))
        else $error("block counter not armed after frame");

    // Store addresses stay inside the buffer
    a_addr_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_st.valid |-> ({1'b0, o_st.store_address} < Span))
        else $error("store address outside buffer");

    // A new frame never lands on a busy hold row
    a_no_hold_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |=> !$past(frame))
        else $error("frame accepted while hold row full");

endmodule

@@ tb/sv/delimited_frame_extractor_tb.sv @@
// Self-checking testbench for delimited_frame_extractor: drives bytes, register
// writes and store-request backpressure, and checks every store request in order.
// Depends on dfe_pkg, the dfe_if channel interfaces and the RTL top level.
module delimited_frame_extractor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dfe_pkg::*;

    localparam int          MAX_PAY      = MAX_PAYLOAD_DEF;
    localparam int          WIN_DEPTH    = MAX_PAY + 1;
    localparam int unsigned ADDR_SPAN    = (BUFFER_BYTES_DEF > 32'd65536) ? 32'd65536
                                                                          : BUFFER_BYTES_DEF;
    localparam int          SETTLE_CYCLES = 2 * (MAX_PAY + 2);
    localparam int          PHASE_ITEMS   = 50;
    localparam int          N_PHASES      = 6;
    localparam int          BULK_FRAMES   = 2;
    localparam int          CYCLE_LIMIT   = 2_000_000;
    localparam int          PROBE_ROWS    = 19;

    // One store request: a payload byte and where it lands in the ring
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic [ADDR_W-1:0] pkt;
        logic [ADDR_W-1:0] rounds;
        logic              last;
    } t_store;

    // Directed byte; where known is set, the request count and first request are pinned
    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              known;
        logic [5:0]        n_req;
        t_store            first;
    } t_probe_row;

    logic i_clk;
    logic i_rst_n;

    dfe_in_if  rx_ch ();
    dfe_out_if st_ch ();
    dfe_cfg_if cfg_ch ();

    delimited_frame_extractor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_st    (st_ch),
        .i_cfg   (cfg_ch)
    );

    // Frame tracker state
    logic [BYTE_W-1:0] rx_hist [0:WIN_DEPTH-1];
    int unsigned       hold_off;
    int unsigned       ring_idx;
    int unsigned       write_base;
    logic [15:0]       wrap_count;
    logic [LEN_W-1:0]  cfg_len;
    logic [PKTS_W-1:0] cfg_pkts;

    t_store      store_q [$];
    int unsigned scan_count;
    t_store      scan_first;

    int tx_gap_pct;
    int sink_stall_pct;
    int fail_count;
    int cycle_cnt;

    // Reset config (length 11): stray end marker, a frame with markers and
    // extreme bytes as payload, an overlapping candidate, a truncated frame
    t_probe_row probe_rows [PROBE_ROWS] = '{
        '{END_MARK,   1'b1, 6'd0,  '0},
        '{START_MARK, 1'b0, 6'd0,  '0},
        '{8'h00,      1'b0, 6'd0,  '0},
        '{8'hFF,      1'b0, 6'd0,  '0},
        '{START_MARK, 1'b0, 6'd0,  '0},
        '{END_MARK,   1'b0, 6'd0,  '0},
        '{8'h55,      1'b0, 6'd0,  '0},
        '{8'hAA,      1'b0, 6'd0,  '0},
        '{8'h01,      1'b0, 6'd0,  '0},
        '{8'h80,      1'b0, 6'd0,  '0},
        '{8'h7F,      1'b0, 6'd0,  '0},
        '{8'hFE,      1'b0, 6'd0,  '0},
        '{END_MARK,   1'b0, 6'd0,  '0},
        '{END_MARK,   1'b1, 6'd11, '{16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0}},
        '{8'h33,      1'b0, 6'd0,  '0},
        '{8'h44,      1'b0, 6'd0,  '0},
        '{END_MARK,   1'b1, 6'd0,  '0},
        '{START_MARK, 1'b0, 6'd0,  '0},
        '{END_MARK,   1'b1, 6'd0,  '0}
    };

    // Register settings per random phase: out-of-range and extreme values included
    logic [LEN_W-1:0]  ph_len  [0:N_PHASES-1] = '{6'd0, 6'd1, 6'd63, 6'd32, 6'd5, 6'd3};
    logic [PKTS_W-1:0] ph_pkts [0:N_PHASES-1] = '{17'd0, 17'd3, PKTS_MAX, 17'h1FFFF,
                                                   17'd50, 17'd2};

    // Clamp the programmed payload length to the supported range
    function automatic int unsigned frame_len();
        if (cfg_len == 0)
            return 1;
        if (cfg_len > MAX_PAY)
            return MAX_PAY;
        return cfg_len;
    endfunction

    // Advance the tracker by one byte and queue the store requests it releases
    function automatic void frame_scan(input logic [BYTE_W-1:0] b);
        int unsigned len;
        int unsigned ring_size;
        int unsigned slot;
        logic        blocked;
        t_store      req;
        len        = frame_len();
        ring_size  = (cfg_pkts == 0) ? 1 : ((cfg_pkts > PKTS_MAX) ? PKTS_MAX : cfg_pkts);
        scan_count = 0;
        scan_first = '0;
        if (hold_off != 0)
            hold_off--;
        blocked = (hold_off >= WIN_DEPTH - len);
        if (b == END_MARK && rx_hist[len] == START_MARK && !blocked) begin
            for (slot = 0; slot < len; slot++) begin
                req.addr   = 16'((write_base + slot) % ADDR_SPAN);
                req.data   = rx_hist[len - 1 - slot];
                req.pkt    = 16'(ring_idx);
                req.rounds = wrap_count;
                req.last   = (slot == len - 1);
                if (slot == 0)
                    scan_first = req;
                store_q = {store_q, req};
            end
            scan_count = len;
            write_base = (write_base + len) % ADDR_SPAN;
            ring_idx++;
            // wrap the ring, also when it was shrunk below the current index
            if (ring_idx >= ring_size) begin
                ring_idx   = 0;
                write_base = 0;
                wrap_count = wrap_count + 16'd1;
            end
            hold_off = WIN_DEPTH;
        end
        for (slot = WIN_DEPTH - 1; slot > 0; slot--)
            rx_hist[slot] = rx_hist[slot - 1];
        rx_hist[0] = b;
    endfunction

    // Compare one store request field by field
    function automatic void check_store(input t_store want, input t_store got);
        if (got.addr !== want.addr) begin
            $error("store_address: expected %0h, actual %0h", want.addr, got.addr);
            fail_count++;
        end
        if (got.data !== want.data) begin
            $error("store_byte: expected %0h, actual %0h", want.data, got.data);
            fail_count++;
        end
        if (got.pkt !== want.pkt) begin
            $error("packet_number: expected %0d, actual %0d", want.pkt, got.pkt);
            fail_count++;
        end
        if (got.rounds !== want.rounds) begin
            $error("round_count: expected %0d, actual %0d", want.rounds, got.rounds);
            fail_count++;
        end
        if (got.last !== want.last) begin
            $error("last_of_frame: expected %0b, actual %0b", want.last, got.last);
            fail_count++;
        end
    endfunction

    // Random byte, with a given percentage forced to a frame marker
    function automatic logic [BYTE_W-1:0] pick_byte(input int unsigned marker_pct);
        if ($urandom_range(99) < marker_pct)
            return $urandom_range(1) ? START_MARK : END_MARK;
        return 8'($urandom);
    endfunction

    // Offer one byte, idling first at random, and track it once accepted
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < tx_gap_pct) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        frame_scan(b);
    endtask

    // Hold the byte input until every queued store request has come out
    task automatic drain_stores();
        rx_ch.valid <= 1'b0;
        do @(posedge i_clk); while (store_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers back to back; junk in the unused length bits
    task automatic program_regs(input logic [LEN_W-1:0] len, input logic [PKTS_W-1:0] pkts);
        logic [CFG_DAT_W-1:0] word;
        word = {11'($urandom), len};
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_PAYLOAD_LENGTH;
        cfg_ch.data  <= word;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_len = word[LEN_W-1:0];
        cfg_ch.index <= REG_BUFFER_PACKETS;
        cfg_ch.data  <= pkts;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_pkts = pkts;
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly well-formed frames, plus wrong lengths, missing end markers and noise
    task automatic random_traffic(input int n_items);
        int          sent;
        int          roll;
        int          body;
        int          k;
        bit          paused;
        logic [7:0]  tail;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            // pause once mid-phase until the output side has caught up
            if (!paused && sent >= n_items / 2) begin
                drain_stores();
                paused = 1'b1;
            end
            roll = $urandom_range(99);
            body = frame_len();
            if (roll >= 70 && roll < 80)
                body = $urandom_range(1) ? body + 1 : body - 1;
            if (roll < 88) begin
                push_byte(START_MARK);
                for (k = 0; k < body; k++)
                    push_byte(pick_byte(10));
                tail = pick_byte(10);
                if (roll >= 80 && tail == END_MARK)
                    tail = START_MARK;
                push_byte(roll < 80 ? END_MARK : tail);
                sent += body + 2;
            end else begin
                k = $urandom_range(1, 6);
                repeat (k) push_byte(pick_byte(25));
                sent += k;
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: stall store requests at random
    initial begin
        st_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            st_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Check every accepted store request against the oldest queued one
    always @(posedge i_clk) begin
        if (i_rst_n && st_ch.valid && st_ch.ready) begin
            if (store_q.size() == 0) begin
                $error("unexpected store request: store_address %0h store_byte %0h",
                       st_ch.store_address, st_ch.store_byte);
                fail_count++;
            end else begin
                check_store(store_q.pop_front(),
                            '{st_ch.store_address, st_ch.store_byte, st_ch.packet_number,
                              st_ch.round_count, st_ch.last_of_frame});
            end
        end
    end

    // Give up after the cycle limit
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $error("timeout after %0d cycles, %0d store requests outstanding",
               cycle_cnt, store_q.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        int r;
        int ph;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = REG_PAYLOAD_LENGTH;
        cfg_ch.data    = '0;
        i_rst_n        = 1'b0;
        fail_count     = 0;
        tx_gap_pct     = 21;
        sink_stall_pct = 84;
        for (r = 0; r < WIN_DEPTH; r++)
            rx_hist[r] = '0;
        hold_off   = 0;
        ring_idx   = 0;
        write_base = 0;
        wrap_count = '0;
        cfg_len    = LEN_RESET;
        cfg_pkts   = PKTS_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes at reset configuration
        for (r = 0; r < PROBE_ROWS; r++) begin
            push_byte(probe_rows[r].rx);
            if (probe_rows[r].known) begin
                if (scan_count != probe_rows[r].n_req) begin
                    $error("request count: expected %0d, actual %0d",
                           probe_rows[r].n_req, scan_count);
                    fail_count++;
                end else if (scan_count != 0) begin
                    check_store(probe_rows[r].first, scan_first);
                end
            end
        end

        // Random phases: sender idles lightly, then heavily, then neither side idles
        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph == 2) begin
                tx_gap_pct     = 84;
                sink_stall_pct = 21;
            end
            if (ph == 4) begin
                tx_gap_pct     = 0;
                sink_stall_pct = 0;
            end
            drain_stores();
            program_regs(ph_len[ph], ph_pkts[ph]);
            random_traffic(PHASE_ITEMS);
        end

        // Back-to-back full-length frames with no idling on either side
        drain_stores();
        program_regs(6'(MAX_PAY), PKTS_MAX);
        repeat (BULK_FRAMES) begin
            push_byte(START_MARK);
            repeat (MAX_PAY) push_byte(8'($urandom));
            push_byte(END_MARK);
        end

        drain_stores();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
